[sv/hts_pkg.sv]
package hts_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TONE_MODE      = 3'd0,
        REG_PEAK_SCALE     = 3'd1,
        REG_HALF_POINT     = 3'd2,
        REG_CONTRAST_POWER = 3'd3,
        REG_TOE_FLARE      = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TONE_OFF     = 2'd0,
        TONE_CHANNEL = 2'd1,
        TONE_LUMA    = 2'd2
    } tone_mode_t;

    // Datapath widths
    localparam int X20_W       = 35;  // x << 4
    localparam int RATIO_DEN_W = 36;  // x20 + s2
    localparam int RATIO_Q_W   = 29;  // one spare quotient bit, zero while s2 is nonzero
    localparam int RATIO_W     = 28;  // Q0.28
    localparam int FRAC_W      = 24;
    localparam int LOG_W       = 29;  // -log2, Q5.24
    localparam int Y_W         = 37;
    localparam int N_W         = Y_W - FRAC_W;
    localparam int EXP_W       = 31;  // Q1.30
    localparam int PROD_W      = 63;  // m2 * e
    localparam int CURVE_W     = 43;  // f, Q13.30
    localparam int FLARE_DEN_W = 44;  // f + t1 << 2
    localparam int GAIN_Q_W    = 21;  // q, up to 2^20
    localparam int NITS_W      = 32;

    typedef struct packed {
        logic active;
        logic kill;
    } item_flags_t;

    localparam int FLAGS_W = $bits(item_flags_t);

    function automatic logic [63:0] isqrt64(input logic [63:0] a);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = a;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q1.30, by repeated square roots starting from 2^-1
    function automatic logic [EXP_W-1:0] root_q30(input int k);
        logic [63:0] v;
        v = 64'd1 << 29;
        for (int j = 1; j <= k; j++)
        begin
            v = isqrt64(v << 30);
        end
        return v[EXP_W-1:0];
    endfunction

endpackage

[sv/hts_div_pipe.sv]
// Restoring divider, one quotient bit per stage.
// quo = num * 2^(QW-1) / den, valid while num < 2 * den.
module hts_div_pipe #(
    parameter int DW = 36,
    parameter int QW = 29,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [QW];
    logic [DW:0]   rem_reg   [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [QW-1:0] quo_reg   [QW];
    logic [SW-1:0] side_reg  [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic          v_in;
        logic [DW:0]   rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_st;
        logic          take;
        logic [DW:0]   diff;
        logic [DW:0]   rem_next;
        logic [QW-1:0] quo_next;

        if (s == 0)
        begin : g_head
            assign v_in    = in_valid;
            assign rem_in  = {1'b0, num};
            assign den_in  = den;
            assign quo_in  = '0;
            assign side_st = side_in;
        end
        else
        begin : g_body
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign quo_in  = quo_reg[s-1];
            assign side_st = side_reg[s-1];
        end

        always_comb
        begin
            take     = rem_in >= {1'b0, den_in};
            diff     = rem_in - {1'b0, den_in};
            rem_next = take ? {diff[DW-1:0], 1'b0} : {rem_in[DW-1:0], 1'b0};
            quo_next = {quo_in[QW-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_in;
                quo_reg[s]  <= quo_next;
                side_reg[s] <= side_st;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

[sv/hts_log2_pipe.sv]
// -log2(r) for r in Q0.28: normalise, then one squaring per fraction bit.
module hts_log2_pipe #(
    parameter int SW = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [hts_pkg::RATIO_W-1:0] ratio,
    input  logic [SW-1:0]               side_in,
    output logic                        out_valid,
    output logic [hts_pkg::LOG_W-1:0]   neg_log,
    output logic [SW-1:0]               side_out
);

    localparam int FW = hts_pkg::FRAC_W;

    logic [4:0]    p_norm;
    logic [31:0]   m_norm;

    logic          nv_reg;
    logic [4:0]    np_reg;
    logic [31:0]   nm_reg;
    logic [SW-1:0] nside_reg;

    logic          sv_reg   [FW];
    logic [4:0]    sp_reg   [FW];
    logic [31:0]   sm_reg   [FW];
    logic [FW-1:0] sf_reg   [FW];
    logic [SW-1:0] sside_reg[FW];

    logic                      lv_reg;
    logic [hts_pkg::LOG_W-1:0] lg_reg;
    logic [SW-1:0]             lside_reg;

    // Leading one of the ratio
    always_comb
    begin
        p_norm = '0;
        for (int i = 0; i < hts_pkg::RATIO_W; i++)
        begin
            if (ratio[i])
            begin
                p_norm = 5'(i);
            end
        end
        m_norm = {4'd0, ratio} << (5'd31 - p_norm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= 1'b0;
        end
        else if (en)
        begin
            nv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            np_reg    <= p_norm;
            nm_reg    <= m_norm;
            nside_reg <= side_in;
        end
    end

    for (genvar k = 0; k < FW; k++)
    begin : g_sq
        logic          v_in;
        logic [4:0]    p_in;
        logic [31:0]   m_in;
        logic [FW-1:0] f_in;
        logic [SW-1:0] side_st;
        logic [63:0]   prod;
        logic [32:0]   sq;
        logic [31:0]   m_next;
        logic [FW-1:0] f_next;

        if (k == 0)
        begin : g_head
            assign v_in    = nv_reg;
            assign p_in    = np_reg;
            assign m_in    = nm_reg;
            assign f_in    = '0;
            assign side_st = nside_reg;
        end
        else
        begin : g_body
            assign v_in    = sv_reg[k-1];
            assign p_in    = sp_reg[k-1];
            assign m_in    = sm_reg[k-1];
            assign f_in    = sf_reg[k-1];
            assign side_st = sside_reg[k-1];
        end

        always_comb
        begin
            prod   = {32'd0, m_in} * {32'd0, m_in};
            sq     = prod[63:31];
            m_next = sq[32] ? sq[32:1] : sq[31:0];
            f_next = {f_in[FW-2:0], sq[32]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sp_reg[k]    <= p_in;
                sm_reg[k]    <= m_next;
                sf_reg[k]    <= f_next;
                sside_reg[k] <= side_st;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg <= 1'b0;
        end
        else if (en)
        begin
            lv_reg <= sv_reg[FW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg_reg    <= {5'd28 - sp_reg[FW-1], {FW{1'b0}}} - {5'd0, sf_reg[FW-1]};
            lside_reg <= sside_reg[FW-1];
        end
    end

    assign out_valid = lv_reg;
    assign neg_log   = lg_reg;
    assign side_out  = lside_reg;

endmodule

[sv/hts_exp2_pipe.sv]
// 2^(-u) for u in Q0.24: one conditional multiply by a root per stage.
module hts_exp2_pipe #(
    parameter int SW = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [hts_pkg::FRAC_W-1:0] frac,
    input  logic [SW-1:0]              side_in,
    output logic                       out_valid,
    output logic [hts_pkg::EXP_W-1:0]  expo,
    output logic [SW-1:0]              side_out
);

    localparam int FW = hts_pkg::FRAC_W;
    localparam int EW = hts_pkg::EXP_W;

    logic          v_reg   [FW];
    logic [FW-1:0] u_reg   [FW];
    logic [EW-1:0] acc_reg [FW];
    logic [SW-1:0] side_reg[FW];

    for (genvar k = 0; k < FW; k++)
    begin : g_mul
        localparam logic [EW-1:0] ROOT = hts_pkg::root_q30(k + 1);

        logic          v_in;
        logic [FW-1:0] u_in;
        logic [EW-1:0] acc_in;
        logic [SW-1:0] side_st;
        logic [2*EW-1:0] prod;
        logic [EW-1:0] acc_next;

        if (k == 0)
        begin : g_head
            assign v_in    = in_valid;
            assign u_in    = frac;
            assign acc_in  = EW'(1) << 30;
            assign side_st = side_in;
        end
        else
        begin : g_body
            assign v_in    = v_reg[k-1];
            assign u_in    = u_reg[k-1];
            assign acc_in  = acc_reg[k-1];
            assign side_st = side_reg[k-1];
        end

        always_comb
        begin
            prod     = {{EW{1'b0}}, acc_in} * {{EW{1'b0}}, ROOT};
            acc_next = u_in[FW-1-k] ? prod[EW+29:30] : acc_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                u_reg[k]    <= u_in;
                acc_reg[k]  <= acc_next;
                side_reg[k] <= side_st;
            end
        end
    end

    assign out_valid = v_reg[FW-1];
    assign expo      = acc_reg[FW-1];
    assign side_out  = side_reg[FW-1];

endmodule

[sv/hdr_tone_scale.sv]
// HDR tone scale: maps one scene-linear sample (signed Q16.16) to display
// light in nits (unsigned Q18.14) along the Daniele-style curve
//   f = m2 * (x / (x + s2))^g,  h = f*f / (f + t1),  nits = 100 * h.
// Input channel: scene_value with in_valid/in_ready. Output channel:
// display_nits and active with out_valid/out_ready. One request may enter
// every clock cycle while the output is not held; each request passes the
// two bit-per-stage dividers (29 and 21 stages), the 24-stage squaring
// log2 and the 24-stage root-multiply exp2.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per
// cycle; write only while the pipeline is empty. Unknown indexes are dropped.
// Reset clears the configuration registers and every stage's valid bit;
// the block starts in the off mode and returns zero with active low.
// When the receiver stalls, the whole pipeline holds in place and in_ready
// drops in the same cycle, so nothing is lost or repeated.
module hdr_tone_scale (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [hts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [31:0]              scene_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hts_pkg::NITS_W-1:0]      display_nits,
    output logic                            active
);

    localparam int FLW = hts_pkg::FLAGS_W;
    localparam int NW  = hts_pkg::N_W;
    localparam int CW  = hts_pkg::CURVE_W;

    // ---------------- configuration registers ----------------
    logic [1:0]  tone_mode_reg;
    logic [31:0] peak_scale_reg;
    logic [31:0] half_point_reg;
    logic [31:0] contrast_power_reg;
    logic [31:0] toe_flare_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_mode_reg      <= hts_pkg::TONE_OFF;
            peak_scale_reg     <= '0;
            half_point_reg     <= '0;
            contrast_power_reg <= '0;
            toe_flare_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hts_pkg::REG_TONE_MODE:      tone_mode_reg      <= cfg_data[1:0];
                hts_pkg::REG_PEAK_SCALE:     peak_scale_reg     <= cfg_data;
                hts_pkg::REG_HALF_POINT:     half_point_reg     <= cfg_data;
                hts_pkg::REG_CONTRAST_POWER: contrast_power_reg <= cfg_data;
                hts_pkg::REG_TOE_FLARE:      toe_flare_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves unless the output is full and held
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------- stage A: qualify and form x + s2 ----------------
    logic                          usable;
    logic                          x_pos;
    logic [hts_pkg::X20_W-1:0]     x20;
    logic                          a_valid_reg;
    logic                          a_active_reg;
    logic [hts_pkg::X20_W-1:0]     a_x20_reg;
    logic [hts_pkg::RATIO_DEN_W-1:0] a_sum_reg;

    always_comb
    begin
        usable = (tone_mode_reg inside {hts_pkg::TONE_CHANNEL, hts_pkg::TONE_LUMA})
                 && (peak_scale_reg != '0) && (half_point_reg != '0)
                 && (contrast_power_reg != '0);
        x_pos  = !scene_value[31] && (scene_value != '0);
        x20    = {scene_value[30:0], 4'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_active_reg <= usable && x_pos;
            a_x20_reg    <= x20;
            a_sum_reg    <= {1'b0, x20} + {4'd0, half_point_reg};
        end
    end

    // ---------------- ratio r = x / (x + s2), Q0.28 ----------------
    logic                            d1_valid;
    logic [hts_pkg::RATIO_Q_W-1:0]   d1_quo;
    logic                            d1_active;
    hts_pkg::item_flags_t            r_flags;

    hts_div_pipe #(
        .DW (hts_pkg::RATIO_DEN_W),
        .QW (hts_pkg::RATIO_Q_W),
        .SW (1)
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .num       ({1'b0, a_x20_reg}),
        .den       (a_sum_reg),
        .side_in   (a_active_reg),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .side_out  (d1_active)
    );

    // Ratio underflow keeps active high but forces a zero result
    always_comb
    begin
        r_flags.active = d1_active;
        r_flags.kill   = !d1_active || (d1_quo[hts_pkg::RATIO_W-1:0] == '0);
    end

    // ---------------- -log2(r) ----------------
    logic                        lg_valid;
    logic [hts_pkg::LOG_W-1:0]   lg;
    logic [FLW-1:0]              lg_side;

    hts_log2_pipe #(
        .SW (FLW)
    ) u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .ratio     (d1_quo[hts_pkg::RATIO_W-1:0]),
        .side_in   (r_flags),
        .out_valid (lg_valid),
        .neg_log   (lg),
        .side_out  (lg_side)
    );

    // ---------------- stage Y: y = g * L ----------------
    logic [60:0]               gl_prod;
    logic                      y_valid_reg;
    logic [hts_pkg::Y_W-1:0]   y_reg;
    logic [FLW-1:0]            y_side_reg;

    assign gl_prod = {29'd0, contrast_power_reg} * {32'd0, lg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            y_valid_reg <= lg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg      <= gl_prod[60:24];
            y_side_reg <= lg_side;
        end
    end

    // ---------------- e = 2^(-frac(y)) ----------------
    logic                        ex_valid;
    logic [hts_pkg::EXP_W-1:0]   ex;
    logic [FLW+NW-1:0]           ex_side;

    hts_exp2_pipe #(
        .SW (FLW + NW)
    ) u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (y_valid_reg),
        .frac      (y_reg[hts_pkg::FRAC_W-1:0]),
        .side_in   ({y_side_reg, y_reg[hts_pkg::Y_W-1:hts_pkg::FRAC_W]}),
        .out_valid (ex_valid),
        .expo      (ex),
        .side_out  (ex_side)
    );

    // ---------------- stage M: m2 * e ----------------
    logic                         m_valid_reg;
    logic [hts_pkg::PROD_W-1:0]   m_prod_reg;
    logic [NW-1:0]                m_n_reg;
    logic [FLW-1:0]               m_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= ex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_prod_reg <= {31'd0, peak_scale_reg} * {32'd0, ex};
            m_n_reg    <= ex_side[NW-1:0];
            m_side_reg <= ex_side[FLW+NW-1:NW];
        end
    end

    // ---------------- stage S: f = prod >> (20 + n) ----------------
    logic [hts_pkg::PROD_W-1:0] f_shift;
    logic                       s_valid_reg;
    logic [CW-1:0]              s_f_reg;
    logic [FLW-1:0]             s_side_reg;

    // Shifts of 64 or more give zero
    always_comb
    begin
        if (m_n_reg >= NW'(44))
        begin
            f_shift = '0;
        end
        else
        begin
            f_shift = m_prod_reg >> (6'd20 + m_n_reg[5:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_f_reg    <= f_shift[CW-1:0];
            s_side_reg <= m_side_reg;
        end
    end

    // ---------------- stage D: den = f + t1 << 2 ----------------
    logic                             dn_valid_reg;
    logic [CW-1:0]                    dn_f_reg;
    logic [hts_pkg::FLARE_DEN_W-1:0]  dn_den_reg;
    logic [FLW-1:0]                   dn_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dn_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_f_reg    <= s_f_reg;
            dn_den_reg  <= {1'b0, s_f_reg} + {10'd0, toe_flare_reg, 2'd0};
            dn_side_reg <= s_side_reg;
        end
    end

    // ---------------- q = f * 2^20 / den ----------------
    // A zero denominator means f is zero, so h comes out zero regardless of q.
    logic                           d2_valid;
    logic [hts_pkg::GAIN_Q_W-1:0]   d2_quo;
    logic [FLW+CW-1:0]              d2_side;

    hts_div_pipe #(
        .DW (hts_pkg::FLARE_DEN_W),
        .QW (hts_pkg::GAIN_Q_W),
        .SW (FLW + CW)
    ) u_gain_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dn_valid_reg),
        .num       ({1'b0, dn_f_reg}),
        .den       (dn_den_reg),
        .side_in   ({dn_side_reg, dn_f_reg}),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    // ---------------- stage H: h = f * q >> 20 ----------------
    logic [63:0]          fq_prod;
    logic                 h_valid_reg;
    logic [CW-1:0]        h_reg;
    hts_pkg::item_flags_t h_flags_reg;

    assign fq_prod = {21'd0, d2_side[CW-1:0]} * {43'd0, d2_quo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            h_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg       <= fq_prod[62:20];
            h_flags_reg <= d2_side[FLW+CW-1:CW];
        end
    end

    // ---------------- stage O: scale to nits, saturate ----------------
    logic [49:0]                  nits_prod;
    logic [33:0]                  nits_wide;
    logic [hts_pkg::NITS_W-1:0]   nits_next;
    logic                         out_valid_reg;
    logic [hts_pkg::NITS_W-1:0]   nits_reg;
    logic                         active_reg;

    always_comb
    begin
        nits_prod = {7'd0, h_reg} * 50'd100;
        nits_wide = nits_prod[49:16];
        if (h_flags_reg.kill)
        begin
            nits_next = '0;
        end
        else if (nits_wide[33:32] != 2'd0)
        begin
            nits_next = '1;
        end
        else
        begin
            nits_next = nits_wide[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nits_reg   <= nits_next;
            active_reg <= h_flags_reg.active;
        end
    end

    assign out_valid    = out_valid_reg;
    assign display_nits = nits_reg;
    assign active       = active_reg;

    // ---------------- assertions ----------------
    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |-> display_nits == '0)
        else $error("inactive result carries nonzero nits");

    a_off_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (tone_mode_reg == hts_pkg::TONE_OFF) |-> !active)
        else $error("active result while mode is off");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> a_valid_reg)
        else $error("accepted request missing from first stage");

    a_kill_output: assert property (@(posedge clk) disable iff (!rst_n)
        en && h_valid_reg && h_flags_reg.kill |=> out_valid && display_nits == '0)
        else $error("killed request produced nonzero nits");

endmodule

[test/hdr_tone_scale_tb.sv]
module hdr_tone_scale_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 107;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_REQS = 1700;
    localparam int DIR_ROWS    = 10;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [hts_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hts_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic signed [31:0]             scene_value;
    logic                           out_valid;
    logic                           out_ready;
    logic [hts_pkg::NITS_W-1:0]     display_nits;
    logic                           active;

    hdr_tone_scale dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .scene_value  (scene_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .display_nits (display_nits),
        .active       (active)
    );

    // Shadow copy of the curve registers
    logic [1:0]  mode_q;
    logic [31:0] m2_q;
    logic [31:0] s2_q;
    logic [31:0] g_q;
    logic [31:0] t1_q;

    typedef struct packed {
        logic [31:0] nits;
        logic        act;
    } nits_result_t;

    nits_result_t nits_queue[$];
    int  failures = 0;
    int  cycles;
    bit  sink_hold;      // long receiver hold-off requested by the stimulus

    // Directed table: typed expectation only where it is obvious
    typedef struct {
        logic [31:0]  x;
        bit           typed;
        nits_result_t want;
    } dir_row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] a);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = a;
        res = '0;
        b   = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Curve prediction for one scene sample
    function automatic nits_result_t tone_curve(input logic [31:0] x);
        nits_result_t o;
        logic [63:0] x20, sum, ratio, mant, frac, lg, y, n, e, v, f, den, q, h, nits;
        int p;
        o = '0;
        if (!(mode_q == hts_pkg::TONE_CHANNEL || mode_q == hts_pkg::TONE_LUMA))
            return o;
        if (m2_q == 0 || s2_q == 0 || g_q == 0)
            return o;
        if (x == 0 || x[31])
            return o;
        o.act = 1'b1;
        x20   = {32'd0, x} << 4;
        sum   = x20 + s2_q;
        ratio = (x20 << 28) / sum;
        if (ratio == 0)
            return o;
        p = 0;
        while (p < 27 && (ratio >> (p + 1)) != 0)
            p++;
        mant = ratio << (31 - p);
        frac = 0;
        for (int i = 0; i < 24; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        lg = (64'(28 - p) << 24) - frac;
        y  = ({32'd0, g_q} * lg) >> 24;
        n  = y >> 24;
        e  = 64'd1 << 30;
        v  = 64'd1 << 29;
        for (int k = 1; k <= 24; k++)
        begin
            v = int_sqrt(v << 30);
            if (y[24 - k])
                e = (e * v) >> 30;
        end
        if (20 + n >= 64)
            f = 0;
        else
            f = ({32'd0, m2_q} * e) >> (20 + n);
        den  = f + ({32'd0, t1_q} << 2);
        q    = (den == 0) ? 64'd0 : (f << 20) / den;
        h    = (f * q) >> 20;
        nits = (64'd100 * h) >> 16;
        o.nits = (nits > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nits[31:0];
        return o;
    endfunction

    // Write enable stays high between back-to-back writes; set_curve drops it
    task automatic write_reg(input hts_pkg::cfg_reg_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            hts_pkg::REG_TONE_MODE:      mode_q = val[1:0];
            hts_pkg::REG_PEAK_SCALE:     m2_q   = val;
            hts_pkg::REG_HALF_POINT:     s2_q   = val;
            hts_pkg::REG_CONTRAST_POWER: g_q    = val;
            hts_pkg::REG_TOE_FLARE:      t1_q   = val;
            default:                     ;
        endcase
    endtask

    task automatic set_curve(input logic [1:0] md, input logic [31:0] m2,
                             input logic [31:0] s2, input logic [31:0] g,
                             input logic [31:0] t1);
        write_reg(hts_pkg::REG_TONE_MODE, {30'd0, md});
        write_reg(hts_pkg::REG_PEAK_SCALE, m2);
        write_reg(hts_pkg::REG_HALF_POINT, s2);
        write_reg(hts_pkg::REG_CONTRAST_POWER, g);
        write_reg(hts_pkg::REG_TOE_FLARE, t1);
        cfg_wr_en <= 1'b0;
    endtask

    // Drop the request line, hold until the pipeline has drained, then a margin
    task automatic drain;
        in_valid <= 1'b0;
        while (nits_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic queue_expected(input nits_result_t want);
        nits_queue.insert(nits_queue.size(), want);
    endtask

    // Offer one request; hold valid and payload until accepted.
    // Valid is left high so the next request can follow directly.
    task automatic send(input logic [31:0] x, input nits_result_t want);
        in_valid    <= 1'b1;
        scene_value <= x;
        do
            @(posedge clk);
        while (!in_ready);
        queue_expected(want);
    endtask

    task automatic send_predicted(input logic [31:0] x);
        send(x, tone_curve(x));
    endtask

    task automatic idle_gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return;
        in_valid <= 1'b0;
        if (roll < 93)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(10, 60)) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_scene();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0: return $urandom;
            1: return $urandom_range(1, 255);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 1000);
            3: return 32'h8000_0000 | $urandom;
            default: return {1'b0, 31'($urandom) >> $urandom_range(0, 20)};
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int roll;
        bit hold_taken;
        hold_taken = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 60)
                out_ready <= 1'b1;
            else if (roll < 95)
                out_ready <= 1'b0;
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(5, 40)) @(posedge clk);
                continue;
            end
            @(posedge clk);
        end
    end

    // Checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        nits_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (nits_queue.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result nits=%h active=%b",
                         $time, display_nits, active);
            end
            else
            begin
                exp_r = nits_queue.pop_front();
                if (display_nits !== exp_r.nits)
                begin
                    failures++;
                    $display("%0t: display_nits expected %h actual %h",
                             $time, exp_r.nits, display_nits);
                end
                if (active !== exp_r.act)
                begin
                    failures++;
                    $display("%0t: active expected %b actual %b",
                             $time, exp_r.act, active);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t rows[DIR_ROWS];
        dir_row_t row;
        int settings_done;
        int rand_count;
        sink_hold     = 1'b0;
        mode_q = '0; m2_q = '0; s2_q = '0; g_q = '0; t1_q = '0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        scene_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the mode is off: everything gives zero, inactive
        send(32'h0001_0000, '{nits: 32'd0, act: 1'b0});
        send(32'h7FFF_FFFF, '{nits: 32'd0, act: 1'b0});
        drain();

        // Typical curve: m2 ~ 1.0, s2 ~ 0.18, g ~ 1.15, t1 ~ 0.04
        set_curve(hts_pkg::TONE_CHANNEL, 32'h0010_0000, 32'h0002_E148, 32'h0126_6666,
                  32'h00A3_D70A);
        rows[0] = '{x: 32'h0000_0000, typed: 1, want: '{32'd0, 1'b0}};
        rows[1] = '{x: 32'hFFFF_FFFF, typed: 1, want: '{32'd0, 1'b0}};
        rows[2] = '{x: 32'h8000_0000, typed: 1, want: '{32'd0, 1'b0}};
        rows[3] = '{x: 32'h0000_0001, typed: 0, want: '0};
        rows[4] = '{x: 32'h0000_2E14, typed: 0, want: '0};
        rows[5] = '{x: 32'h0001_0000, typed: 0, want: '0};
        rows[6] = '{x: 32'h0064_0000, typed: 0, want: '0};
        rows[7] = '{x: 32'h7FFF_FFFF, typed: 0, want: '0};
        rows[8] = '{x: 32'h5555_5555, typed: 0, want: '0};
        rows[9] = '{x: 32'h2AAA_AAAA, typed: 0, want: '0};
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.typed)
                send(row.x, row.want);
            else
                send_predicted(row.x);
        end
        drain();

        // Luminance mode, huge gain to saturate, zero flare
        set_curve(hts_pkg::TONE_LUMA, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001,
                  32'h0);
        send_predicted(32'h7FFF_FFFF);
        send_predicted(32'h0000_0001);
        drain();
        // Ratio underflow: tiny x against the largest s2, active but zero
        set_curve(hts_pkg::TONE_CHANNEL, 32'h0010_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_predicted(32'h0000_0001);
        send_predicted(32'h0000_0100);
        send_predicted(32'h7FFF_FFFF);
        drain();
        // Zero gain, zero s2, zero g and mode three all switch the curve off
        set_curve(hts_pkg::TONE_CHANNEL, 32'h0, 32'h1000, 32'h0100_0000, 32'h1);
        send(32'h0001_0000, '{nits: 32'd0, act: 1'b0});
        drain();
        set_curve(hts_pkg::TONE_CHANNEL, 32'h1000, 32'h0, 32'h0100_0000, 32'h1);
        send(32'h0001_0000, '{nits: 32'd0, act: 1'b0});
        drain();
        set_curve(hts_pkg::TONE_CHANNEL, 32'h1000, 32'h1000, 32'h0, 32'h1);
        send(32'h0001_0000, '{nits: 32'd0, act: 1'b0});
        drain();
        set_curve(2'd3, 32'h1000, 32'h1000, 32'h0100_0000, 32'h1);
        send(32'h0001_0000, '{nits: 32'd0, act: 1'b0});
        drain();

        // Random phases, each with fresh register settings
        rand_count    = 0;
        settings_done = 0;
        while (rand_count < RANDOM_REQS)
        begin
            if (settings_done % 4 == 3)
                set_curve(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                          $urandom);
            else
                set_curve(2'($urandom_range(1, 2)),
                          $urandom_range(32'h0001_0000, 32'h2000_0000),
                          $urandom_range(32'h0000_1000, 32'h0100_0000),
                          $urandom_range(32'h0040_0000, 32'h0300_0000),
                          $urandom >> $urandom_range(0, 31));
            settings_done++;
            // Long receiver hold-off with the sender still pushing
            if (settings_done == 2)
                sink_hold = 1'b1;
            repeat (200)
            begin
                send_predicted(rand_scene());
                rand_count++;
                idle_gap();
            end
            drain();
        end

        drain();
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[hdr_tone_scale.f]
sv/hts_pkg.sv
sv/hts_div_pipe.sv
sv/hts_log2_pipe.sv
sv/hts_exp2_pipe.sv
sv/hdr_tone_scale.sv
test/hdr_tone_scale_tb.sv
